/* rtl/swlt_pkg.sv */
// Shared types and constants for the stop-and-wait link transmitter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package swlt_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RETRY_W  = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned PARSE_W  = 3;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
  localparam logic [RETRY_W-1:0] RETRY_MAX       = 4'd15;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_BYTE  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_OPEN  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLOSE = 3'd4;

  // Result actions
  localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_IFRAME = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DISC   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_UA     = 3'd4;

  // Result status
  localparam logic [STATUS_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd3;

  // Link phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_OPEN  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WRITE = 2'd2;
  localparam logic [PHASE_W-1:0] PH_CLOSE = 2'd3;

  // Frame bytes
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ADDR_CMD  = 8'h03;
  localparam logic [BYTE_W-1:0] ADDR_RSP  = 8'h01;
  localparam logic [BYTE_W-1:0] CTL_SET   = 8'h03;
  localparam logic [BYTE_W-1:0] CTL_UA    = 8'h07;
  localparam logic [BYTE_W-1:0] CTL_DISC  = 8'h0B;
  localparam logic [BYTE_W-1:0] CTL_RR0   = 8'h05;
  localparam logic [BYTE_W-1:0] CTL_RR1   = 8'h85;
  localparam logic [BYTE_W-1:0] CTL_REJ0  = 8'h01;
  localparam logic [BYTE_W-1:0] CTL_REJ1  = 8'h81;
  localparam logic [BYTE_W-1:0] CTL_I0    = 8'h00;
  localparam logic [BYTE_W-1:0] CTL_I1    = 8'h40;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_TICK,
    KIND_REQ,
    KIND_NOP
  } kind_e;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    kind_e               kind;
    logic [PHASE_W-1:0]  req_phase;
    logic [BYTE_W-1:0]   data;
    logic                is_flag;
    logic                is_addr;
    logic                ctrl_ok;
  } item_t;

endpackage

`default_nettype wire

/* rtl/swlt_if.sv */
// Valid/ready channel interfaces for the input and result words.
// Depends on swlt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swlt_in_if;
  logic                          valid;
  logic                          ready;
  logic [swlt_pkg::OPCODE_W-1:0] opcode;
  logic [swlt_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface swlt_out_if;
  logic                          valid;
  logic                          ready;
  logic [swlt_pkg::ACTION_W-1:0] action;
  logic                          frame_seq;
  logic [swlt_pkg::STATUS_W-1:0] status;

  modport source (output valid, output action, output frame_seq, output status, input ready);
  modport sink   (input valid, input action, input frame_seq, input status, output ready);
endinterface

`default_nettype wire

/* rtl/swlt_front.sv */
// Front end: takes input words and classifies opcode and received byte.
// Depends on swlt_pkg and swlt_in_if.
`timescale 1ns / 1ps
`default_nettype none

module swlt_front (
  swlt_in_if.sink          in_i,
  input  wire logic        full_i,
  output logic             push_o,
  output swlt_pkg::item_t  item_o
);

  logic [swlt_pkg::BYTE_W-1:0] b;

  assign b         = in_i.rx_byte;
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  always_comb begin
    item_o.req_phase = swlt_pkg::PH_IDLE;
    unique case (in_i.opcode)
      swlt_pkg::OP_BYTE: item_o.kind = swlt_pkg::KIND_BYTE;
      swlt_pkg::OP_TICK: item_o.kind = swlt_pkg::KIND_TICK;
      swlt_pkg::OP_OPEN: begin
        item_o.kind      = swlt_pkg::KIND_REQ;
        item_o.req_phase = swlt_pkg::PH_OPEN;
      end
      swlt_pkg::OP_WRITE: begin
        item_o.kind      = swlt_pkg::KIND_REQ;
        item_o.req_phase = swlt_pkg::PH_WRITE;
      end
      swlt_pkg::OP_CLOSE: begin
        item_o.kind      = swlt_pkg::KIND_REQ;
        item_o.req_phase = swlt_pkg::PH_CLOSE;
      end
      default: item_o.kind = swlt_pkg::KIND_NOP;
    endcase
    item_o.data    = b;
    item_o.is_flag = (b == swlt_pkg::FLAG_BYTE);
    item_o.is_addr = (b == swlt_pkg::ADDR_CMD) || (b == swlt_pkg::ADDR_RSP);
    item_o.ctrl_ok = (b == swlt_pkg::CTL_SET)  || (b == swlt_pkg::CTL_UA)   ||
                     (b == swlt_pkg::CTL_DISC) || (b == swlt_pkg::CTL_RR0)  ||
                     (b == swlt_pkg::CTL_RR1)  || (b == swlt_pkg::CTL_REJ0) ||
                     (b == swlt_pkg::CTL_REJ1) || (b == swlt_pkg::CTL_I0)   ||
                     (b == swlt_pkg::CTL_I1);
  end

endmodule

`default_nettype wire

/* rtl/swlt_queue.sv */
// Two-entry queue of classified words between the front and back ends.
// Depends on swlt_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module swlt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire swlt_pkg::item_t  item_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output swlt_pkg::item_t       item_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  swlt_pkg::item_t       mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]         count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("queue holds more words than it has entries");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> count_q == (PtrW+1)'(Depth))
    else $error("queue lost a word while full");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == (PtrW+1)'(1)) && pop_i && !push_i |=> !valid_o)
    else $error("queue not empty after last word left");

endmodule

`default_nettype wire

/* rtl/swlt_back.sv */
// Back end: frame parser, link phase machine, retry counting and result register.
// Depends on swlt_pkg and swlt_out_if.
`timescale 1ns / 1ps
`default_nettype none

module swlt_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire swlt_pkg::item_t               item_i,
  output logic                               pop_o,
  input  wire logic [swlt_pkg::RETRY_W-1:0]  retry_limit_i,
  swlt_out_if.source                         out_o
);

  // Parser states
  localparam logic [swlt_pkg::PARSE_W-1:0] PS_START = 3'd0;
  localparam logic [swlt_pkg::PARSE_W-1:0] PS_FLAG  = 3'd1;
  localparam logic [swlt_pkg::PARSE_W-1:0] PS_ADDR  = 3'd2;
  localparam logic [swlt_pkg::PARSE_W-1:0] PS_CTRL  = 3'd3;
  localparam logic [swlt_pkg::PARSE_W-1:0] PS_BCC   = 3'd4;

  logic [swlt_pkg::PARSE_W-1:0]  ps_q, ps_d;
  logic [swlt_pkg::BYTE_W-1:0]   addr_q, addr_d, ctrl_q, ctrl_d;
  logic [swlt_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic                          seq_q, seq_d;
  logic [swlt_pkg::RETRY_W-1:0]  retry_q, retry_d, retry_inc;

  logic                          out_valid_q;
  logic [swlt_pkg::ACTION_W-1:0] action_q, action_d;
  logic [swlt_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          frame_done, reply_ok;
  logic [swlt_pkg::ACTION_W-1:0] resend_act;
  logic [swlt_pkg::BYTE_W-1:0]   rr_want;

  assign pop_o = valid_i && (!out_valid_q || out_o.ready);

  assign out_o.valid     = out_valid_q;
  assign out_o.action    = action_q;
  assign out_o.status    = status_q;
  assign out_o.frame_seq = seq_q;

  always_comb begin
    unique case (phase_q)
      swlt_pkg::PH_OPEN:  resend_act = swlt_pkg::ACT_SET;
      swlt_pkg::PH_WRITE: resend_act = swlt_pkg::ACT_IFRAME;
      default:            resend_act = swlt_pkg::ACT_DISC;
    endcase
  end

  assign retry_inc = (retry_q < swlt_pkg::RETRY_MAX) ? retry_q + 1'b1 : retry_q;
  assign rr_want   = seq_q ? swlt_pkg::CTL_RR0 : swlt_pkg::CTL_RR1;

  // Byte parser: next state and whether a closing flag completes a frame.
  always_comb begin
    addr_d     = addr_q;
    ctrl_d     = ctrl_q;
    frame_done = 1'b0;
    unique case (ps_q)
      PS_FLAG: begin
        if (item_i.is_flag) begin
          ps_d = PS_FLAG;
        end else if (item_i.is_addr) begin
          addr_d = item_i.data;
          ps_d   = PS_ADDR;
        end else begin
          ps_d = PS_START;
        end
      end
      PS_ADDR: begin
        if (item_i.is_flag) begin
          ps_d = PS_FLAG;
        end else if (item_i.ctrl_ok) begin
          ctrl_d = item_i.data;
          ps_d   = PS_CTRL;
        end else begin
          ps_d = PS_START;
        end
      end
      PS_CTRL: begin
        if (item_i.is_flag) begin
          ps_d = PS_FLAG;
        end else if (item_i.data == (addr_q ^ ctrl_q)) begin
          ps_d = PS_BCC;
        end else begin
          ps_d = PS_START;
        end
      end
      PS_BCC: begin
        ps_d       = PS_START;
        frame_done = item_i.is_flag;
      end
      default: ps_d = item_i.is_flag ? PS_FLAG : PS_START;
    endcase
  end

  always_comb begin
    unique case (phase_q)
      swlt_pkg::PH_OPEN:
        reply_ok = (addr_q == swlt_pkg::ADDR_CMD) && (ctrl_q == swlt_pkg::CTL_UA);
      swlt_pkg::PH_WRITE:
        reply_ok = (addr_q == swlt_pkg::ADDR_CMD) && (ctrl_q == rr_want);
      default:
        reply_ok = (addr_q == swlt_pkg::ADDR_RSP) && (ctrl_q == swlt_pkg::CTL_DISC);
    endcase
  end

  // Phase machine, one classified word per cycle while no untaken result is held.
  logic [swlt_pkg::PARSE_W-1:0] ps_n;
  logic [swlt_pkg::BYTE_W-1:0]  addr_n, ctrl_n;

  always_comb begin
    ps_n     = ps_q;
    addr_n   = addr_q;
    ctrl_n   = ctrl_q;
    phase_d  = phase_q;
    seq_d    = seq_q;
    retry_d  = retry_q;
    action_d = swlt_pkg::ACT_NONE;
    status_d = (phase_q == swlt_pkg::PH_IDLE) ? swlt_pkg::ST_IDLE : swlt_pkg::ST_WAIT;
    case (item_i.kind)
      swlt_pkg::KIND_REQ: begin
        retry_d = '0;
        ps_n    = PS_START;
        if (retry_limit_i == '0) begin
          phase_d  = swlt_pkg::PH_IDLE;
          status_d = swlt_pkg::ST_FAIL;
        end else begin
          phase_d  = item_i.req_phase;
          status_d = swlt_pkg::ST_WAIT;
          unique case (item_i.req_phase)
            swlt_pkg::PH_OPEN:  action_d = swlt_pkg::ACT_SET;
            swlt_pkg::PH_WRITE: action_d = swlt_pkg::ACT_IFRAME;
            default:            action_d = swlt_pkg::ACT_DISC;
          endcase
        end
      end
      swlt_pkg::KIND_TICK: begin
        if (phase_q != swlt_pkg::PH_IDLE) begin
          retry_d = retry_inc;
          ps_n    = PS_START;
          if (retry_inc >= retry_limit_i) begin
            phase_d  = swlt_pkg::PH_IDLE;
            status_d = swlt_pkg::ST_FAIL;
          end else begin
            action_d = resend_act;
            status_d = swlt_pkg::ST_WAIT;
          end
        end
      end
      swlt_pkg::KIND_BYTE: begin
        if (phase_q != swlt_pkg::PH_IDLE) begin
          ps_n   = ps_d;
          addr_n = addr_d;
          ctrl_n = ctrl_d;
          if (frame_done) begin
            ps_n = PS_START;
            if (reply_ok) begin
              phase_d  = swlt_pkg::PH_IDLE;
              status_d = swlt_pkg::ST_OK;
              if (phase_q == swlt_pkg::PH_WRITE) begin
                seq_d = !seq_q;
              end
              if (phase_q == swlt_pkg::PH_CLOSE) begin
                action_d = swlt_pkg::ACT_UA;
              end
            end else begin
              action_d = resend_act;
              status_d = swlt_pkg::ST_WAIT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q        <= PS_START;
      addr_q      <= '0;
      ctrl_q      <= '0;
      phase_q     <= swlt_pkg::PH_IDLE;
      seq_q       <= 1'b0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        ps_q        <= ps_n;
        addr_q      <= addr_n;
        ctrl_q      <= ctrl_n;
        phase_q     <= phase_d;
        seq_q       <= seq_d;
        retry_q     <= retry_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_q <= action_d;
      status_q <= status_d;
    end
  end

  a_idle_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == swlt_pkg::PH_IDLE |-> ps_q == PS_START)
    else $error("parser left its start state while no request is pending");

  a_ua_ends_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q == swlt_pkg::ACT_UA |-> status_q == swlt_pkg::ST_OK)
    else $error("final UA sent without a completed close");

  a_fail_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && status_d == swlt_pkg::ST_FAIL |=> phase_q == swlt_pkg::PH_IDLE)
    else $error("request failed but the link did not return to idle");

  a_write_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && phase_q == swlt_pkg::PH_WRITE && status_d == swlt_pkg::ST_OK
    |=> seq_q != $past(seq_q))
    else $error("acknowledged write did not toggle the sequence bit");

endmodule

`default_nettype wire

/* rtl/stop_and_wait_link_transmitter.sv */
// A word accepted at the input is written into a queue entry; its result word is
// registered as the word leaves the queue, which waits while an untaken result is held.
// Throughput: one word per cycle while the result side is ready; the back end retires
// one queued word per cycle and the two-entry queue keeps the input ready while the
// result register drains in step; a stall on the result side holds the back end.
// Reset (rst_ni low, asynchronous): link idle, parser hunting for a flag, sequence bit
// and retry count zero, queue empty, no result pending, retry limit back to three.
`timescale 1ns / 1ps
`default_nettype none

module stop_and_wait_link_transmitter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  swlt_in_if.sink                            in_i,
  swlt_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swlt_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [swlt_pkg::PDATA_W-1:0]  pwdata,
  output logic      [swlt_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  // The front end decodes each incoming word into a compact class (request, tick,
  // received byte or nothing) and precomputes the byte tests that do not depend on
  // link state. The queue lets the front keep taking words while the back end waits
  // for its result register to be drained.
  swlt_pkg::item_t            front_item, back_item;
  logic                       q_push, q_full, q_valid, q_pop;
  logic [swlt_pkg::RETRY_W-1:0] retry_limit_q;
  logic                       cfg_wr, sel_limit;

  swlt_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .item_o (front_item)
  );

  swlt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  // The back end holds the whole link state and produces exactly one result word for
  // every classified word it retires.
  swlt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (back_item),
    .pop_o         (q_pop),
    .retry_limit_i (retry_limit_q),
    .out_o         (out_o)
  );

  // Configuration: the retry limit is at byte address zero; the two low address bits
  // pick a byte lane only, so any address below four reaches it. The back end reads it
  // directly; the user must write the register only while the link is quiet, unchecked.
  assign pready    = 1'b1;
  assign sel_limit = !paddr[2];
  assign cfg_wr    = psel && penable && pwrite && sel_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= swlt_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      retry_limit_q <= pwdata[swlt_pkg::RETRY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata[swlt_pkg::RETRY_W-1:0] = retry_limit_q;
    end
  end

endmodule

`default_nettype wire

/* tb/swlt_reply_checker.sv */
// Checker for the stop-and-wait link transmitter: watches both word channels and the
// configuration bus, predicts each result word and compares it. Depends on swlt_pkg, swlt_if.
`timescale 1ns / 1ps

module swlt_reply_checker #(
  parameter logic [swlt_pkg::PADDR_W-1:0] RETRY_LIMIT_ADDR = '0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  swlt_in_if                             in_i,
  swlt_out_if                            out_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [swlt_pkg::PADDR_W-1:0]   paddr,
  input  logic [swlt_pkg::PDATA_W-1:0]   pwdata,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o
);

  typedef enum logic [swlt_pkg::PARSE_W-1:0] {
    HUNT,
    GOT_FLAG,
    GOT_ADDR,
    GOT_CTRL,
    GOT_BCC
  } parser_e;

  typedef struct packed {
    logic [swlt_pkg::ACTION_W-1:0] action;
    logic                          frame_seq;
    logic [swlt_pkg::STATUS_W-1:0] status;
  } reply_t;

  parser_e                        parser;
  logic [swlt_pkg::BYTE_W-1:0]    addr_q;
  logic [swlt_pkg::BYTE_W-1:0]    ctrl_q;
  logic [swlt_pkg::PHASE_W-1:0]   link_phase;
  logic                           ns_bit;
  logic [swlt_pkg::RETRY_W-1:0]   retries;
  logic [swlt_pkg::RETRY_W-1:0]   retry_limit;
  reply_t                         expected_replies[$];

  function automatic logic ctrl_valid(input logic [swlt_pkg::BYTE_W-1:0] c);
    case (c)
      swlt_pkg::CTL_SET, swlt_pkg::CTL_UA, swlt_pkg::CTL_DISC, swlt_pkg::CTL_RR0,
      swlt_pkg::CTL_RR1, swlt_pkg::CTL_REJ0, swlt_pkg::CTL_REJ1, swlt_pkg::CTL_I0,
      swlt_pkg::CTL_I1: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Moves the supervision-frame parser on by one byte; true when a frame has closed.
  function automatic logic frame_complete(input logic [swlt_pkg::BYTE_W-1:0] b);
    logic done;
    done = 1'b0;
    case (parser)
      GOT_FLAG: begin
        if (b == swlt_pkg::FLAG_BYTE) begin
          parser = GOT_FLAG;
        end else if (b == swlt_pkg::ADDR_CMD || b == swlt_pkg::ADDR_RSP) begin
          addr_q = b;
          parser = GOT_ADDR;
        end else begin
          parser = HUNT;
        end
      end
      GOT_ADDR: begin
        if (b == swlt_pkg::FLAG_BYTE) begin
          parser = GOT_FLAG;
        end else if (ctrl_valid(b)) begin
          ctrl_q = b;
          parser = GOT_CTRL;
        end else begin
          parser = HUNT;
        end
      end
      GOT_CTRL: begin
        if (b == swlt_pkg::FLAG_BYTE) parser = GOT_FLAG;
        else if (b == (addr_q ^ ctrl_q)) parser = GOT_BCC;
        else parser = HUNT;
      end
      GOT_BCC: begin
        parser = HUNT;
        done = (b == swlt_pkg::FLAG_BYTE);
      end
      default: parser = (b == swlt_pkg::FLAG_BYTE) ? GOT_FLAG : HUNT;
    endcase
    return done;
  endfunction

  // A resend always restarts the parser.
  function automatic logic [swlt_pkg::ACTION_W-1:0] resend_action();
    parser = HUNT;
    case (link_phase)
      swlt_pkg::PH_OPEN:  return swlt_pkg::ACT_SET;
      swlt_pkg::PH_WRITE: return swlt_pkg::ACT_IFRAME;
      default:            return swlt_pkg::ACT_DISC;
    endcase
  endfunction

  function automatic reply_t next_reply(input logic [swlt_pkg::OPCODE_W-1:0] op,
                                        input logic [swlt_pkg::BYTE_W-1:0]   b);
    reply_t                      r;
    logic                        ok;
    logic [swlt_pkg::BYTE_W-1:0] want_rr;
    r.action = swlt_pkg::ACT_NONE;
    r.status = (link_phase == swlt_pkg::PH_IDLE) ? swlt_pkg::ST_IDLE : swlt_pkg::ST_WAIT;
    ok = 1'b0;
    if (op == swlt_pkg::OP_OPEN || op == swlt_pkg::OP_WRITE || op == swlt_pkg::OP_CLOSE) begin
      case (op)
        swlt_pkg::OP_OPEN:  link_phase = swlt_pkg::PH_OPEN;
        swlt_pkg::OP_WRITE: link_phase = swlt_pkg::PH_WRITE;
        default:            link_phase = swlt_pkg::PH_CLOSE;
      endcase
      retries = '0;
      parser  = HUNT;
      if (retries >= retry_limit) begin
        link_phase = swlt_pkg::PH_IDLE;
        r.status   = swlt_pkg::ST_FAIL;
      end else begin
        r.action = resend_action();
        r.status = swlt_pkg::ST_WAIT;
      end
    end else if (link_phase != swlt_pkg::PH_IDLE && op == swlt_pkg::OP_TICK) begin
      if (retries != swlt_pkg::RETRY_MAX) retries = retries + 1'b1;
      if (retries >= retry_limit) begin
        link_phase = swlt_pkg::PH_IDLE;
        parser     = HUNT;
        r.status   = swlt_pkg::ST_FAIL;
      end else begin
        r.action = resend_action();
        r.status = swlt_pkg::ST_WAIT;
      end
    end else if (link_phase != swlt_pkg::PH_IDLE && op == swlt_pkg::OP_BYTE) begin
      if (frame_complete(b)) begin
        case (link_phase)
          swlt_pkg::PH_OPEN:
            ok = (addr_q == swlt_pkg::ADDR_CMD && ctrl_q == swlt_pkg::CTL_UA);
          swlt_pkg::PH_WRITE: begin
            // The receiver acknowledges by asking for the other sequence bit.
            want_rr = ns_bit ? swlt_pkg::CTL_RR0 : swlt_pkg::CTL_RR1;
            ok = (addr_q == swlt_pkg::ADDR_CMD && ctrl_q == want_rr);
            if (ok) ns_bit = ~ns_bit;
          end
          default: begin
            ok = (addr_q == swlt_pkg::ADDR_RSP && ctrl_q == swlt_pkg::CTL_DISC);
            if (ok) r.action = swlt_pkg::ACT_UA;
          end
        endcase
        if (ok) begin
          link_phase = swlt_pkg::PH_IDLE;
          parser     = HUNT;
          r.status   = swlt_pkg::ST_OK;
        end else begin
          r.action = resend_action();
          r.status = swlt_pkg::ST_WAIT;
        end
      end
    end
    r.frame_seq = ns_bit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      parser      = HUNT;
      addr_q      = '0;
      ctrl_q      = '0;
      link_phase  = swlt_pkg::PH_IDLE;
      ns_bit      = 1'b0;
      retries     = '0;
      retry_limit = swlt_pkg::RETRY_LIMIT_RST;
      expected_replies.delete();
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RETRY_LIMIT_ADDR) begin
        retry_limit = pwdata[swlt_pkg::RETRY_W-1:0];
      end
      if (in_i.valid && in_i.ready) begin
        expected_replies.push_back(next_reply(in_i.opcode, in_i.rx_byte));
      end
      if (out_i.valid && out_i.ready) begin
        got.action    = out_i.action;
        got.frame_seq = out_i.frame_seq;
        got.status    = out_i.status;
        if (expected_replies.size() == 0) begin
          $display("%0t: result word with none expected: expected nothing, got %h",
                   $time, got);
          errors_o++;
        end else begin
          want = expected_replies.pop_front();
          if (got.action !== want.action) begin
            $display("%0t: action expected %0d, got %0d", $time, want.action, got.action);
            errors_o++;
          end
          if (got.frame_seq !== want.frame_seq) begin
            $display("%0t: frame_seq expected %0d, got %0d",
                     $time, want.frame_seq, got.frame_seq);
            errors_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            errors_o++;
          end
        end
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

/* tb/tb_stop_and_wait_link_transmitter.sv */
// Top of the testbench for the stop-and-wait link transmitter: clock, reset, stimulus
// and verdict. Depends on swlt_pkg, swlt_if, the block itself and swlt_reply_checker.
`timescale 1ns / 1ps

module tb_stop_and_wait_link_transmitter;

  // The only register, the retry limit, is register zero at byte address zero.
  localparam logic [swlt_pkg::PADDR_W-1:0]  RETRY_LIMIT_ADDR = '0;
  // Opcodes that the block does not use; it must answer them without acting.
  localparam logic [swlt_pkg::OPCODE_W-1:0] OP_UNUSED_LO     = 3'd5;
  localparam logic [swlt_pkg::OPCODE_W-1:0] OP_UNUSED_HI     = 3'd7;
  // Far beyond the slowest correct run: about a thousand words, each with its gaps
  // and stalls, plus the drains between phases.
  localparam int unsigned                   CYCLE_LIMIT      = 200000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [swlt_pkg::PADDR_W-1:0] paddr;
  logic [swlt_pkg::PDATA_W-1:0] pwdata;
  logic [swlt_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int unsigned        errors;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  int unsigned        words_sent = 0;
  logic               stalls_on = 1'b1;

  swlt_in_if  in_ch ();
  swlt_out_if out_ch ();

  stop_and_wait_link_transmitter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swlt_reply_checker #(
    .RETRY_LIMIT_ADDR (RETRY_LIMIT_ADDR)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #10 clk_i = ~clk_i;

  // The result side stalls in roughly a quarter of the cycles while stalls are on.
  always @(posedge clk_i) begin
    out_ch.ready <= !(stalls_on && $urandom_range(0, 99) < 24);
  end

  // Watchdog: a run that hangs is a failed run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_stop_and_wait_link_transmitter: errors");
      $finish;
    end
  end

  // Presents one word and holds it until it is taken. Ready is sampled on the falling
  // edge, where everything driven at the rising edge has settled, so the acceptance
  // seen here is the one at the following rising edge. The task is entered and left
  // in the time step of a rising edge.
  task automatic drive_word(input logic [swlt_pkg::OPCODE_W-1:0] op,
                            input logic [swlt_pkg::BYTE_W-1:0]   data);
    logic taken;
    if (stalls_on && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  // Withholds further words until every result word that was predicted has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // A write is a setup phase followed by an access phase; pready is always high.
  task automatic apb_write(input logic [swlt_pkg::PADDR_W-1:0] addr,
                           input logic [swlt_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A well-formed supervision frame: flag, address, control, BCC1 and a closing flag.
  task automatic send_frame(input logic [swlt_pkg::BYTE_W-1:0] a,
                            input logic [swlt_pkg::BYTE_W-1:0] c);
    drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
    drive_word(swlt_pkg::OP_BYTE, a);
    drive_word(swlt_pkg::OP_BYTE, c);
    drive_word(swlt_pkg::OP_BYTE, a ^ c);
    drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
  endtask

  // Damaged frames: a corrupted byte, a frame cut short, repeated opening flags, or a
  // header abandoned by a flag after the address or after the control byte. The last
  // three still end in a complete frame, since the flag restarts the parser.
  task automatic send_broken_frame(input logic [swlt_pkg::BYTE_W-1:0] a,
                                   input logic [swlt_pkg::BYTE_W-1:0] c);
    logic [swlt_pkg::BYTE_W-1:0] frame_bytes [5];
    int                          cut;
    frame_bytes = '{swlt_pkg::FLAG_BYTE, a, c, a ^ c, swlt_pkg::FLAG_BYTE};
    cut = 5;
    case ($urandom_range(0, 4))
      0: frame_bytes[$urandom_range(1, 4)] = 8'($urandom);
      1: cut = $urandom_range(1, 4);
      2: drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
      3: begin
        drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
        drive_word(swlt_pkg::OP_BYTE, a);
      end
      default: begin
        drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
        drive_word(swlt_pkg::OP_BYTE, a);
        drive_word(swlt_pkg::OP_BYTE, c);
      end
    endcase
    for (int i = 0; i < cut; i++) drive_word(swlt_pkg::OP_BYTE, frame_bytes[i]);
  endtask

  function automatic logic [swlt_pkg::BYTE_W-1:0] any_ctrl();
    case ($urandom_range(0, 8))
      0:       return swlt_pkg::CTL_SET;
      1:       return swlt_pkg::CTL_UA;
      2:       return swlt_pkg::CTL_DISC;
      3:       return swlt_pkg::CTL_RR0;
      4:       return swlt_pkg::CTL_RR1;
      5:       return swlt_pkg::CTL_REJ0;
      6:       return swlt_pkg::CTL_REJ1;
      7:       return swlt_pkg::CTL_I0;
      default: return swlt_pkg::CTL_I1;
    endcase
  endfunction

  function automatic logic [swlt_pkg::OPCODE_W-1:0] any_request();
    case ($urandom_range(0, 3))
      0:       return swlt_pkg::OP_OPEN;
      1, 2:    return swlt_pkg::OP_WRITE;
      default: return swlt_pkg::OP_CLOSE;
    endcase
  endfunction

  // One request followed by a few events from the line. The likeliest is the reply
  // that the request waits for; the rest are other frames, timeouts, damaged frames,
  // noise, unused opcodes and requests that cut in. For a write the acknowledgement
  // asks for either sequence bit, so both the wanted and the unwanted one turn up.
  task automatic run_request();
    logic [swlt_pkg::OPCODE_W-1:0] req;
    logic [swlt_pkg::BYTE_W-1:0]   reply_addr;
    logic [swlt_pkg::BYTE_W-1:0]   reply_ctrl;
    int                            pick;
    int                            events;
    req = any_request();
    case (req)
      swlt_pkg::OP_OPEN: begin
        reply_addr = swlt_pkg::ADDR_CMD;
        reply_ctrl = swlt_pkg::CTL_UA;
      end
      swlt_pkg::OP_WRITE: begin
        reply_addr = swlt_pkg::ADDR_CMD;
        reply_ctrl = $urandom_range(0, 1) ? swlt_pkg::CTL_RR1 : swlt_pkg::CTL_RR0;
      end
      default: begin
        reply_addr = swlt_pkg::ADDR_RSP;
        reply_ctrl = swlt_pkg::CTL_DISC;
      end
    endcase
    drive_word(req, 8'($urandom));
    events = $urandom_range(1, 6);
    for (int i = 0; i < events; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_frame(reply_addr, reply_ctrl);
        if (req != swlt_pkg::OP_WRITE && $urandom_range(0, 3) != 0) break;
        if (req == swlt_pkg::OP_WRITE) begin
          reply_ctrl = (reply_ctrl == swlt_pkg::CTL_RR0) ? swlt_pkg::CTL_RR1
                                                         : swlt_pkg::CTL_RR0;
        end
      end else if (pick < 55) begin
        send_frame($urandom_range(0, 1) ? swlt_pkg::ADDR_CMD : swlt_pkg::ADDR_RSP,
                   any_ctrl());
      end else if (pick < 72) begin
        drive_word(swlt_pkg::OP_TICK, 8'($urandom));
      end else if (pick < 87) begin
        send_broken_frame(reply_addr, reply_ctrl);
      end else if (pick < 94) begin
        drive_word(swlt_pkg::OP_BYTE, 8'($urandom));
      end else if (pick < 97) begin
        drive_word(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom));
      end else begin
        drive_word(any_request(), 8'($urandom));
      end
    end
  endtask

  // Random phases, each under its own retry limit. A limit of zero fails every
  // request at once, so that phase is kept short. The third phase runs without any
  // idling on either side.
  logic [swlt_pkg::RETRY_W-1:0] phase_limit  [6] = '{4'd1, 4'd15, 4'd5, 4'd0, 4'd2, 4'd3};
  int unsigned                  phase_budget [6] = '{170, 170, 170, 30, 170, 190};

  initial begin
    int unsigned target;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = swlt_pkg::OP_BYTE;
    in_ch.rx_byte  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset limit of three. Words while idle are ignored.
    drive_word(OP_UNUSED_HI, 8'hFF);
    drive_word(swlt_pkg::OP_TICK, 8'h00);
    drive_word(swlt_pkg::OP_BYTE, swlt_pkg::FLAG_BYTE);
    // Open with one timeout before the UA arrives.
    drive_word(swlt_pkg::OP_OPEN, 8'h00);
    drive_word(swlt_pkg::OP_TICK, 8'hFF);
    send_frame(swlt_pkg::ADDR_CMD, swlt_pkg::CTL_UA);
    // Write with sequence bit zero, an unused opcode while busy, then the RR asking
    // for bit one, which toggles the sequence bit.
    drive_word(swlt_pkg::OP_WRITE, 8'h55);
    drive_word(OP_UNUSED_LO, 8'hAA);
    send_frame(swlt_pkg::ADDR_CMD, swlt_pkg::CTL_RR1);
    // Close: the receiver's DISC is answered by the final UA.
    drive_word(swlt_pkg::OP_CLOSE, 8'h00);
    send_frame(swlt_pkg::ADDR_RSP, swlt_pkg::CTL_DISC);
    // A request that cuts into a pending one starts afresh with no retries used.
    drive_word(swlt_pkg::OP_OPEN, 8'h00);
    drive_word(swlt_pkg::OP_WRITE, 8'h00);
    drive_word(swlt_pkg::OP_TICK, 8'h00);
    drive_word(swlt_pkg::OP_TICK, 8'h00);
    // The limit lowered below the retries already used: the next timeout fails.
    wait_drained();
    apb_write(RETRY_LIMIT_ADDR, swlt_pkg::PDATA_W'(1));
    drive_word(swlt_pkg::OP_TICK, 8'h00);
    // A limit of zero fails a request at once.
    wait_drained();
    apb_write(RETRY_LIMIT_ADDR, swlt_pkg::PDATA_W'(0));
    drive_word(swlt_pkg::OP_CLOSE, 8'h00);

    phase_limit[5] = 4'($urandom_range(1, 15));
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      apb_write(RETRY_LIMIT_ADDR, swlt_pkg::PDATA_W'(phase_limit[p]));
      stalls_on = (p != 2);
      target = words_sent + phase_budget[p];
      while (words_sent < target) run_request();
    end

    // Let the last results arrive, then watch a while longer for stray ones.
    wait_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_stop_and_wait_link_transmitter: clean");
    end else begin
      $display("tb_stop_and_wait_link_transmitter: errors");
    end
    $finish;
  end

endmodule

/* stop_and_wait_link_transmitter.f */
rtl/swlt_pkg.sv
rtl/swlt_if.sv
rtl/swlt_front.sv
rtl/swlt_queue.sv
rtl/swlt_back.sv
rtl/stop_and_wait_link_transmitter.sv
tb/swlt_reply_checker.sv
tb/tb_stop_and_wait_link_transmitter.sv
